@@ hdl/tts_pkg.sv @@
// Shared definitions for the text token scanner.
// Result kinds, error causes, register indexes and configuration type.
// No dependencies.
package tts_pkg;

  localparam int MAX_TOKEN_LENGTH_DEF = 1023;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DELIM = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_NEWLINE = 2'd0;
  localparam logic [1:0] CAUSE_EOF     = 2'd1;
  localparam logic [1:0] CAUSE_LENGTH  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHARS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_ON     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMENTS_ON  = 2'd3;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

@@ hdl/text_token_scanner_core.sv @@
// Text token scanner top level: front end, bundle queue and back end.
// Depends on tts_pkg, tts_front, tts_queue and tts_back.
//
// Takes one text byte per cycle on the slave stream (s_tlast marks end of
// input, its byte ignored) and emits token bytes, token ends, delimiters
// and errors on the master stream. The front end queues a bundle of up
// to three results per byte; the back end hands these out one word per
// cycle while the receiver is ready; input runs at one byte per cycle
// while the queue is not full and each byte yields at most one result.
// The two-entry bundle queue lets the input run ahead while a result
// waits. Configuration must be written on the cfg channel only while
// the block is idle, not enforced by it; cfg_ready is always high.
module text_token_scanner_core import tts_pkg::*; #(
  parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF,
  parameter int LEN_W = $clog2(MAX_TOKEN_LENGTH + 2),
  parameter int DATA_W = ((11 + LEN_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,  // data_byte
  input  logic                   s_tlast,  // end_of_input
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // token_char, was_quoted, token_length, error_cause, zero padding
  output logic [DATA_W-1:0]      m_tdata,
  output logic [1:0]             m_tuser   // kind
);

  localparam int RES_W = 13 + LEN_W;
  localparam int BUNDLE_W = 2 + MAX_RESULTS * RES_W;

  cfg_wr_t               cfg_wr;
  logic                  push;
  logic                  queue_full;
  logic [BUNDLE_W-1:0]   bundle_in;
  logic                  pop;
  logic                  q_valid;
  logic [BUNDLE_W-1:0]   bundle_out;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  tts_front #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
    .LEN_W(LEN_W),
    .RES_W(RES_W),
    .BUNDLE_W(BUNDLE_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_wr(cfg_wr),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_byte(s_tdata),
    .in_eof(s_tlast),
    .push(push),
    .queue_full(queue_full),
    .bundle(bundle_in)
  );

  tts_queue #(
    .W(BUNDLE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data(bundle_in),
    .full(queue_full),
    .pop(pop),
    .not_empty(q_valid),
    .rd_data(bundle_out)
  );

  tts_back #(
    .LEN_W(LEN_W),
    .RES_W(RES_W),
    .BUNDLE_W(BUNDLE_W),
    .DATA_W(DATA_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(bundle_out),
    .pop(pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data(m_tdata),
    .out_kind(m_tuser)
  );

endmodule

@@ hdl/tts_front.sv @@
// Front end of the token scanner: configuration registers, scan state and
// per-byte classification into a bundle of up to three results.
// Depends on tts_pkg.
module tts_front import tts_pkg::*; #(
  parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF,
  parameter int LEN_W = $clog2(MAX_TOKEN_LENGTH + 2),
  parameter int RES_W = 13 + LEN_W,
  parameter int BUNDLE_W = 2 + MAX_RESULTS * RES_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  cfg_wr_t             cfg_wr,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_eof,
  output logic                push,
  input  logic                queue_full,
  output logic [BUNDLE_W-1:0] bundle
);

  localparam int CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_TOKEN_LENGTH + 1);
  localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(MAX_TOKEN_LENGTH);

  typedef enum logic [2:0] {
    M_SKIP, M_COMMENT, M_QUOTE, M_ESC, M_FIRST, M_UNQ
  } mode_t;

  typedef struct packed {
    logic [1:0]       cause;
    logic [LEN_W-1:0] len;
    logic             q;
    logic [7:0]       ch;
    logic [1:0]       kind;
  } res_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       last;
    logic [7:0]       pend;
    logic             pv;
    logic [LEN_W-1:0] len;
    logic [1:0]       n;
    res_t [2:0]       res;
  } work_t;

  logic [CFG_DATA_W-1:0] max_chars;
  logic [7:0]            delimiter_char;
  logic                  delimiter_on;
  logic                  comments_on;

  mode_t            scan_mode;
  logic [7:0]       last_char;
  logic [7:0]       pending_char;
  logic             pending_valid;
  logic [LEN_W-1:0] length_count;

  work_t w_next;

  function automatic logic c_space(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic logic c_alpha(logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction
  function automatic logic c_digit(logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction
  function automatic logic c_alnum(logic [7:0] b);
    return c_alpha(b) || c_digit(b);
  endfunction
  function automatic logic c_punct(logic [7:0] b);
    return b >= 8'd33 && b <= 8'd126 && !c_alnum(b);
  endfunction
  function automatic logic c_white(logic [7:0] b);
    return c_space(b) || b == ":";
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return delimiter_on && b == delimiter_char;
  endfunction

  function automatic logic breaks(logic [7:0] l, logic [7:0] t, logic [7:0] n);
    logic r;
    if (c_alpha(t) || t == "_") r = !(c_alnum(l) || l == "." || l == "_");
    else if (c_digit(t)) r = !(c_alnum(l) || l == "." || l == "-" || l == "_");
    else if (t == 8'd0) r = 1'b1;
    else if (c_white(t)) r = 1'b1;
    else if (c_punct(t) && t != "." && t != "-" && t != "=") r = 1'b1;
    else if (t == ".") r = !(c_digit(l) || c_digit(n) || (c_alpha(l) && c_alpha(n)));
    else if (t == "-") r = !(c_space(l) && (c_digit(n) || n == "."));
    else r = 1'b0;
    return r;
  endfunction

  function automatic work_t emit(work_t w, logic [1:0] k, logic [7:0] ch,
                                 logic q, logic [LEN_W-1:0] len, logic [1:0] c);
    work_t r;
    r = w;
    if (w.n != 2'd3) begin
      r.res[w.n].kind  = k;
      r.res[w.n].ch    = ch;
      r.res[w.n].q     = q;
      r.res[w.n].len   = len;
      r.res[w.n].cause = c;
      r.n = w.n + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t grow(work_t w);
    work_t r;
    r = w;
    if (w.len < LEN_SAT) r.len = w.len + LEN_W'(1);
    return r;
  endfunction

  function automatic logic over_cap(logic [LEN_W-1:0] len);
    logic [CMP_W-1:0] cap;
    cap = CMP_W'(max_chars);
    if (cap > CAP_MAX) cap = CAP_MAX;
    return max_chars != '0 && CMP_W'(len) > cap;
  endfunction

  function automatic work_t feed(work_t w, logic [7:0] b);
    work_t r;
    logic [7:0] d;
    r = w;
    d = b;
    case (w.mode)
      M_COMMENT: begin
        if (b == 8'd10) begin
          if (is_delim(b)) r = emit(r, KIND_DELIM, 8'd0, 1'b0, '0, CAUSE_NONE);
          r.mode = M_SKIP;
        end
      end
      M_QUOTE: begin
        if (b == 8'd10) begin
          r = emit(r, KIND_ERROR, 8'd0, 1'b1, r.len, CAUSE_NEWLINE);
          r.mode = M_SKIP;
        end else if (b == "\\") begin
          r.mode = M_ESC;
        end else if (b == "\"") begin
          r = emit(r, KIND_END, 8'd0, 1'b1, r.len, CAUSE_NONE);
          r.mode = M_SKIP;
        end else begin
          r = grow(r);
          r = emit(r, KIND_CHAR, b, 1'b1, r.len, CAUSE_NONE);
          if (over_cap(r.len)) begin
            r = emit(r, KIND_ERROR, 8'd0, 1'b1, r.len, CAUSE_LENGTH);
            r.mode = M_SKIP;
          end
        end
      end
      M_ESC: begin
        case (b)
          "a": d = 8'd7;
          "b": d = 8'd8;
          "f": d = 8'd12;
          "n": d = 8'd10;
          "r": d = 8'd13;
          "t": d = 8'd9;
          "v": d = 8'd11;
          default: d = b;
        endcase
        r = grow(r);
        r = emit(r, KIND_CHAR, d, 1'b1, r.len, CAUSE_NONE);
        r.mode = M_QUOTE;
      end
      M_FIRST: begin
        r.pend = b;
        r.pv   = 1'b1;
        r.mode = M_UNQ;
      end
      default: begin
        if (is_delim(b)) begin
          r = emit(r, KIND_DELIM, 8'd0, 1'b0, '0, CAUSE_NONE);
        end else if (c_white(b)) begin
          r.mode = w.mode;
        end else if (b == "#" && comments_on) begin
          r.mode = M_COMMENT;
        end else if (b == "\"") begin
          r.len  = '0;
          r.last = b;
          r.mode = M_QUOTE;
        end else begin
          r.len  = LEN_W'(1);
          r.last = b;
          r = emit(r, KIND_CHAR, b, 1'b0, r.len, CAUSE_NONE);
          r.mode = M_FIRST;
        end
      end
    endcase
    return r;
  endfunction

  // End of input for every mode but an open unquoted token.
  function automatic work_t finish_base(work_t w);
    work_t r;
    r = w;
    case (w.mode)
      M_QUOTE, M_ESC: r = emit(r, KIND_ERROR, 8'd0, 1'b1, r.len, CAUSE_EOF);
      M_FIRST:        r = emit(r, KIND_END, 8'd0, 1'b0, r.len, CAUSE_NONE);
      default:        r.n = w.n;
    endcase
    r.mode = M_SKIP;
    r.pv   = 1'b0;
    return r;
  endfunction

  function automatic work_t judge(work_t w, logic [7:0] nx, logic eof);
    work_t r;
    logic [7:0] cur;
    r = w;
    cur = w.pend;
    r.pv = 1'b0;
    if (is_delim(cur) || breaks(w.last, cur, nx)) begin
      r = emit(r, KIND_END, 8'd0, 1'b0, r.len, CAUSE_NONE);
      r.mode = M_SKIP;
      r = feed(r, cur);
      if (eof) r = finish_base(r);
      else     r = feed(r, nx);
    end else begin
      r = grow(r);
      r.last = cur;
      r = emit(r, KIND_CHAR, cur, 1'b0, r.len, CAUSE_NONE);
      if (eof || over_cap(r.len)) begin
        // cap cut or end of input: the lookahead byte is dropped
        r = emit(r, KIND_END, 8'd0, 1'b0, r.len, CAUSE_NONE);
        r.mode = M_SKIP;
      end else begin
        r.pend = nx;
        r.pv   = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    work_t w;
    w.mode = scan_mode;
    w.last = last_char;
    w.pend = pending_char;
    w.pv   = pending_valid;
    w.len  = length_count;
    w.n    = 2'd0;
    w.res  = '0;
    if (in_eof) begin
      if (w.mode == M_UNQ) begin
        w = judge(w, 8'd0, 1'b1);
        w.mode = M_SKIP;
        w.pv   = 1'b0;
      end else begin
        w = finish_base(w);
      end
    end else if (w.mode == M_UNQ) begin
      w = judge(w, in_byte, 1'b0);
    end else begin
      w = feed(w, in_byte);
    end
    w_next = w;
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready && w_next.n != 2'd0;
  assign bundle   = {w_next.n, w_next.res};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars      <= '0;
      delimiter_char <= '0;
      delimiter_on   <= 1'b0;
      comments_on    <= 1'b1;
      scan_mode      <= M_SKIP;
      last_char      <= '0;
      pending_char   <= '0;
      pending_valid  <= 1'b0;
      length_count   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_wr.index)
          REG_MAX_CHARS:   max_chars      <= cfg_wr.data;
          REG_DELIM_CHAR:  delimiter_char <= cfg_wr.data[7:0];
          REG_DELIM_ON:    delimiter_on   <= cfg_wr.data[0];
          REG_COMMENTS_ON: comments_on    <= cfg_wr.data[0];
          default:         comments_on    <= comments_on;
        endcase
      end
      if (in_valid && in_ready) begin
        scan_mode     <= w_next.mode;
        last_char     <= w_next.last;
        pending_char  <= w_next.pend;
        pending_valid <= w_next.pv;
        length_count  <= w_next.len;
      end
    end
  end

endmodule

@@ hdl/tts_queue.sv @@
// Short queue of result bundles between scanner front and output back end.
// Depends on tts_pkg for the default depth.
module tts_queue import tts_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

@@ hdl/tts_back.sv @@
// Back end of the token scanner: holds one result bundle and hands its
// results out one word at a time. Depends on tts_pkg.
module tts_back import tts_pkg::*; #(
  parameter int LEN_W = 11,
  parameter int RES_W = 13 + LEN_W,
  parameter int BUNDLE_W = 2 + MAX_RESULTS * RES_W,
  parameter int DATA_W = ((11 + LEN_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  logic [BUNDLE_W-1:0] q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_data,
  output logic [1:0]          out_kind
);

  typedef struct packed {
    logic [1:0]       cause;
    logic [LEN_W-1:0] len;
    logic             q;
    logic [7:0]       ch;
    logic [1:0]       kind;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t [2:0] res;
  } bundle_t;

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  res_t       sel;
  logic       take;
  logic       last_taken;

  assign sel        = cur.res[idx];
  assign out_valid  = cur_valid;
  assign out_kind   = sel.kind;
  assign out_data   = DATA_W'({sel.cause, sel.len, sel.q, sel.ch});
  assign take       = cur_valid && out_ready;
  assign last_taken = take && (idx == cur.n - 2'd1);
  assign pop        = q_valid && (!cur_valid || last_taken);

  always_ff @(posedge clk) begin
    if (pop) cur <= bundle_t'(q_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (last_taken) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

@@ verif/text_token_scanner_core_tb.sv @@
// Self-checking testbench for text_token_scanner_core: streams bytes in,
// predicts every token word in a scoreboard class and checks the output stream.
// Depends on tts_pkg and the scanner RTL.
module text_token_scanner_core_tb;
  import tts_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE = 20;

  class token_scoreboard;
    typedef enum logic [2:0] {
      SKIP, COMMENT, QUOTE, ESCAPE, FIRST, UNQUOTED
    } scan_e;
    typedef struct {
      logic [1:0]  kind;
      logic [7:0]  ch;
      logic        quoted;
      logic [10:0] len;
      logic [1:0]  cause;
    } token_word_t;

    token_word_t due[$];
    int errors, words_seen, bytes_fed;
    int step_words;
    logic [9:0] cap_reg;
    logic [7:0] delim_char;
    logic delim_on, comment_on;
    scan_e mode;
    logic [7:0] prev_ch, held_ch;
    logic held;
    int unsigned run_len;

    function new();
      cap_reg = 0; delim_char = 0; delim_on = 0; comment_on = 1;
      mode = SKIP; prev_ch = 0; held_ch = 0; held = 0; run_len = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAX_CHARS:   cap_reg = val;
        REG_DELIM_CHAR:  delim_char = val[7:0];
        REG_DELIM_ON:    delim_on = val[0];
        REG_COMMENTS_ON: comment_on = val[0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] k, logic [7:0] c, logic q, int unsigned l, logic [1:0] e);
      token_word_t w;
      if (step_words >= MAX_RESULTS) return;
      w.kind = k; w.ch = c; w.quoted = q; w.len = l[10:0]; w.cause = e;
      due.push_back(w);
      step_words++;
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction
    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction
    function bit is_space(logic [7:0] b);
      return b == " " || (b >= 9 && b <= 13);
    endfunction
    function bit is_punct(logic [7:0] b);
      return b >= 33 && b <= 126 && !is_alpha(b) && !is_digit(b);
    endfunction
    function bit hit_delim(logic [7:0] b);
      return delim_on && b == delim_char;
    endfunction

    function void grow();
      if (run_len < MAX_TOKEN_LENGTH_DEF + 1) run_len++;
    endfunction
    function bit over_cap();
      int unsigned c;
      c = cap_reg;
      if (c == 0) return 0;
      if (c > MAX_TOKEN_LENGTH_DEF) c = MAX_TOKEN_LENGTH_DEF;
      return run_len > c;
    endfunction

    function bit splits(logic [7:0] l, logic [7:0] t, logic [7:0] n);
      bit l_aln;
      l_aln = is_alpha(l) || is_digit(l);
      if (is_alpha(t) || t == "_") return !(l_aln || l == "." || l == "_");
      if (is_digit(t)) return !(l_aln || l == "." || l == "-" || l == "_");
      if (t == 0) return 1;
      if (is_space(t) || t == ":") return 1;
      if (is_punct(t) && t != "." && t != "-" && t != "=") return 1;
      if (t == ".")
        return !(is_digit(l) || is_digit(n) || (is_alpha(l) && is_alpha(n)));
      if (t == "-") return !(is_space(l) && (is_digit(n) || n == "."));
      return 0;
    endfunction

    function void feed(logic [7:0] b);
      logic [7:0] d;
      case (mode)
        COMMENT: begin
          if (b == 8'h0a) begin
            if (hit_delim(b)) push(KIND_DELIM, 0, 0, 0, CAUSE_NONE);
            mode = SKIP;
          end
        end
        QUOTE: begin
          if (b == 8'h0a) begin
            push(KIND_ERROR, 0, 1, run_len, CAUSE_NEWLINE);
            mode = SKIP;
          end else if (b == "\\") begin
            mode = ESCAPE;
          end else if (b == "\"") begin
            push(KIND_END, 0, 1, run_len, CAUSE_NONE);
            mode = SKIP;
          end else begin
            grow();
            push(KIND_CHAR, b, 1, run_len, CAUSE_NONE);
            if (over_cap()) begin
              push(KIND_ERROR, 0, 1, run_len, CAUSE_LENGTH);
              mode = SKIP;
            end
          end
        end
        ESCAPE: begin
          case (b)
            "a": d = 7;
            "b": d = 8;
            "f": d = 12;
            "n": d = 10;
            "r": d = 13;
            "t": d = 9;
            "v": d = 11;
            default: d = b;
          endcase
          grow();
          push(KIND_CHAR, d, 1, run_len, CAUSE_NONE);
          mode = QUOTE;
        end
        FIRST: begin
          held_ch = b; held = 1; mode = UNQUOTED;
        end
        default: begin
          if (hit_delim(b)) begin
            push(KIND_DELIM, 0, 0, 0, CAUSE_NONE);
          end else if (is_space(b) || b == ":") begin
          end else if (b == "#" && comment_on) begin
            mode = COMMENT;
          end else if (b == "\"") begin
            run_len = 0; prev_ch = b; mode = QUOTE;
          end else begin
            run_len = 0; grow(); prev_ch = b;
            push(KIND_CHAR, b, 0, run_len, CAUSE_NONE);
            mode = FIRST;
          end
        end
      endcase
    endfunction

    function void judge(logic [7:0] nx, bit eof);
      logic [7:0] cur;
      cur = held_ch;
      held = 0;
      if (hit_delim(cur) || splits(prev_ch, cur, nx)) begin
        push(KIND_END, 0, 0, run_len, CAUSE_NONE);
        mode = SKIP;
        feed(cur);
        if (eof) close_stream();
        else feed(nx);
        return;
      end
      grow();
      prev_ch = cur;
      push(KIND_CHAR, cur, 0, run_len, CAUSE_NONE);
      if (eof || over_cap()) begin
        push(KIND_END, 0, 0, run_len, CAUSE_NONE);
        mode = SKIP;
        return;
      end
      held_ch = nx; held = 1;
    endfunction

    function void close_stream();
      case (mode)
        QUOTE, ESCAPE: push(KIND_ERROR, 0, 1, run_len, CAUSE_EOF);
        FIRST: push(KIND_END, 0, 0, run_len, CAUSE_NONE);
        UNQUOTED: judge(0, 1);
        default: ;
      endcase
      mode = SKIP;
      held = 0;
    endfunction

    // Work out the words caused by one accepted byte.
    function void note_byte(logic [7:0] b, logic eof);
      step_words = 0;
      bytes_fed++;
      if (eof) close_stream();
      else if (mode == UNQUOTED) judge(b, 0);
      else feed(b);
    endfunction

    function void check_word(logic [1:0] kind, logic [23:0] data);
      token_word_t w;
      words_seen++;
      if (due.size() == 0) begin
        $display("%0t: unexpected word kind=%0d data=%h", $time, kind, data);
        errors++;
        return;
      end
      w = due.pop_front();
      if (kind !== w.kind) begin
        $display("%0t: kind exp %0d act %0d", $time, w.kind, kind); errors++;
      end
      if (data[7:0] !== w.ch) begin
        $display("%0t: token_char exp %h act %h", $time, w.ch, data[7:0]); errors++;
      end
      if (data[8] !== w.quoted) begin
        $display("%0t: was_quoted exp %0d act %0d", $time, w.quoted, data[8]); errors++;
      end
      if (data[19:9] !== w.len) begin
        $display("%0t: token_length exp %0d act %0d", $time, w.len, data[19:9]); errors++;
      end
      if (data[21:20] !== w.cause) begin
        $display("%0t: error_cause exp %0d act %0d", $time, w.cause, data[21:20]); errors++;
      end
      if (data[23:22] !== 2'b00) begin
        $display("%0t: padding exp 0 act %b", $time, data[23:22]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;
  logic [1:0] m_tuser;

  token_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int phases = 0;

  text_token_scanner_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: alternate free-running stretches with random stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (rst) m_tready <= 0;
    else if (stall_phase < 100) m_tready <= 1;
    else if (stall_phase < 200) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata);
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= b;
    s_tlast <= eof;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, eof);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], 0);
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic drain();
    s_tvalid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0, 1, 2: return 8'($urandom_range("a", "z"));
      3: return 8'($urandom_range("A", "Z"));
      4, 5: return 8'($urandom_range("0", "9"));
      6: return ".";
      7: return "-";
      8: return "_";
      9: return "=";
      10, 11: return " ";
      12: return ":";
      13: return 8'h0a;
      14: return "#";
      15: return "\"";
      16: return sb.delim_char;
      17: return 8'($urandom_range(128, 255));
      18: return 0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_quoted();
    int n;
    string esc;
    esc = "abfnrtvq\"\\x";
    n = $urandom_range(0, 8);
    send_byte("\"", 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte("\\", 0);
        send_byte(($urandom_range(0, 5) == 0) ? 8'h0a : esc[$urandom_range(0, 10)], 0);
      end else begin
        send_byte(($urandom_range(0, 19) == 0) ? 8'h0a : 8'($urandom_range(32, 126)), 0);
      end
    end
    if ($urandom_range(0, 7) != 0) send_byte("\"", 0);
  endtask

  task automatic random_run(input int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0: begin send_quoted(); k += 4; end
        1: begin send_text("# note"); send_byte(8'h0a, 0); k += 7; end
        2: begin send_byte(8'($urandom_range(0, 255)), 1); k++; end
        default: begin send_byte(pick_byte(), 0); k++; end
      endcase
    end
    send_byte(8'($urandom_range(0, 255)), 1);
    drain();
    phases++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: breaking rules, quotes, escapes, comments and end of input.
    send_text("ab.c x-5 -.5 a=b 1.2e x_y:z ");
    send_byte(0, 0);
    send_byte(8'hff, 0);
    send_text("\"q\\n\\z\" #c");
    send_byte(8'h0a, 0);
    send_text("\"open");
    send_byte(8'h0a, 0);
    send_text("\"tail");
    send_byte(8'h00, 1);
    send_text("w");
    send_byte(8'hff, 1);
    drain();

    random_run(70);

    write_reg(REG_MAX_CHARS, 3);
    write_reg(REG_DELIM_CHAR, ",");
    write_reg(REG_DELIM_ON, 1);
    write_reg(REG_COMMENTS_ON, 0);
    send_text("abcdef \"abcdef\" \"a\\tbcd\" a,b");
    send_byte(0, 1);
    drain();
    random_run(70);

    write_reg(REG_MAX_CHARS, 1023);
    write_reg(REG_DELIM_CHAR, 8'h0a);
    write_reg(REG_COMMENTS_ON, 1);
    random_run(45);
    // The first run ended with a drain, so nothing is outstanding; carry on.
    random_run(25);

    write_reg(REG_MAX_CHARS, 1);
    write_reg(REG_DELIM_CHAR, 255);
    random_run(55);

    write_reg(REG_MAX_CHARS, 0);
    write_reg(REG_DELIM_CHAR, 0);
    write_reg(REG_DELIM_ON, 1);
    random_run(55);

    $display("Fed %0d bytes over %0d phases, checked %0d words across cap, delimiter",
             sb.bytes_fed, phases, sb.words_seen);
    $display("and comment settings.");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.due.size() != 0) $display("%0t: %0d words never arrived", $time, sb.due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
